// ===== hw/rtl/icn_pkg.sv =====
package icn_pkg;

  typedef enum logic [1:0] {
    CMD_TICK        = 2'd0,
    CMD_QUERY       = 2'd1,
    CMD_SLEEP_START = 2'd2,
    CMD_SLEEP_END   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        command;
    logic [15:0] counter_readback;
    logic [63:0] sleep_ns;
  } in_item_t;

  typedef struct packed {
    logic [63:0] value;
    logic [63:0] tick_count;
    logic [15:0] reload_value;
  } out_item_t;

  localparam int RATE_W = 17;
  localparam int DIVR_W = 16;
  localparam int NPT_W  = 26;

  // rate unit outputs
  typedef struct packed {
    logic              busy;
    logic [DIVR_W-1:0] reload_divisor;
    logic [NPT_W-1:0]  ns_per_tick;
  } rate_t;

  // sleep conversion stage towards the state stage
  typedef struct packed {
    cmd_t        command;
    logic [15:0] rb;
    logic [15:0] cnt;
  } front_t;

  // state stage towards the scaling stages
  typedef struct packed {
    logic [63:0] base;
    logic [15:0] x;
    logic [63:0] ticks;
    logic [15:0] reload;
  } mid_t;

  localparam int STAGES = 8;

  localparam logic [RATE_W-1:0] RATE_MAX     = 17'd62500;
  localparam logic [RATE_W-1:0] RATE_SLOWEST = 17'd18;
  localparam logic [DIVR_W-1:0] DIV_SLOWEST  = 16'hFFFF;
  localparam logic [DIVR_W-1:0] DIV_RESET    = 16'd59659;
  localparam logic [NPT_W-1:0]  NPT_RESET    = 26'd49999930;

  localparam longint unsigned CNT_FREQ_NUMER = 64'd3579545;
  localparam longint unsigned CNT_FREQ_DENOM = 64'd3;
  localparam longint unsigned NS_SCALE       = 64'd3000000000;
  localparam longint unsigned FRAC_NUM       = 64'd600000000;
  localparam longint unsigned FRAC_DEN       = 64'd715909;

  // serial divider
  localparam int DVD_W = 22;
  localparam int DSR_W = 22;
  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

  // ns per tick = div * NPT_INT + (div * NPT_REM) / CNT_FREQ_NUMER
  localparam longint unsigned NPT_INT   = NS_SCALE / CNT_FREQ_NUMER;
  localparam longint unsigned NPT_REM   = NS_SCALE % CNT_FREQ_NUMER;
  localparam int              NPT_Y_W   = 35;
  localparam int              NPT_SHIFT = 36;
  localparam longint unsigned NPT_RECIP = (64'd1 << NPT_SHIFT) / CNT_FREQ_NUMER;
  localparam int              NPT_P_W   = 50;
  localparam int              NPT_Q_W   = 13;

  // x * FRAC_NUM / FRAC_DEN = x * SCL_INT + (x * SCL_REM) / FRAC_DEN
  localparam longint unsigned SCL_INT   = FRAC_NUM / FRAC_DEN;
  localparam longint unsigned SCL_REM   = FRAC_NUM % FRAC_DEN;
  localparam int              SCL_SHIFT = 45;
  localparam longint unsigned SCL_RECIP = (64'd1 << SCL_SHIFT) / FRAC_DEN;
  localparam int              SCL_Q_W   = 13;

  // sleep count estimate from sleep_ns[25:8]
  localparam int              SLP_SHIFT = 32;
  localparam longint unsigned SLP_K     = ((64'd1 << 40) * FRAC_DEN) / FRAC_NUM;
  localparam int              SLP_Q_W   = 17;
  localparam int              SLP_NS_W  = 26;

  localparam logic [17:0] SLEEP_SKID = 18'd64;
  localparam logic [17:0] SLEEP_MAX  = 18'h0FFFF;

endpackage

// ===== hw/rtl/icn_rate.sv =====
module icn_rate (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [icn_pkg::RATE_W-1:0]  cfg_wdata,
  output icn_pkg::rate_t              rate
);
  import icn_pkg::*;

  typedef enum logic [2:0] {R_IDLE, R_DIV, R_MUL, R_EST, R_CHK, R_FIX} rstate_t;

  rstate_t            state_r;
  logic [DIVR_W-1:0]  div_r;
  logic [NPT_W-1:0]   npt_r;
  logic [DVD_W-1:0]   dvd_r;
  logic [DSR_W-1:0]   rem_r;
  logic [DSR_W-1:0]   dsr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [NPT_Y_W-1:0] y_r;
  logic [NPT_W-1:0]   a_r;
  logic [NPT_Q_W-1:0] qe_r;
  logic [NPT_Y_W-1:0] m_r;

  logic [RATE_W-1:0]  hz;
  logic [DSR_W:0]     t;
  logic               ge;
  logic [DSR_W-1:0]   rem_step;
  logic [DVD_W-1:0]   dvd_step;
  logic [NPT_P_W-1:0] pr;
  logic [NPT_Y_W-1:0] fr;

  always_comb begin
    hz       = (cfg_wdata > RATE_MAX) ? RATE_MAX : cfg_wdata;
    // one restoring step per cycle, quotient shifts in where the dividend leaves
    t        = {rem_r, dvd_r[DVD_W-1]};
    ge       = t >= {1'b0, dsr_r};
    rem_step = ge ? DSR_W'(t - {1'b0, dsr_r}) : t[DSR_W-1:0];
    dvd_step = {dvd_r[DVD_W-2:0], ge};
    // quotient estimate, low by at most one
    pr       = NPT_P_W'(y_r) * NPT_P_W'(NPT_RECIP);
    fr       = y_r - m_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      div_r   <= DIV_RESET;
      npt_r   <= NPT_RESET;
    end else begin
      case (state_r)
        R_IDLE: begin
          if (cfg_we) begin
            if (hz <= RATE_SLOWEST) begin
              div_r   <= DIV_SLOWEST;
              state_r <= R_MUL;
            end else begin
              dvd_r   <= DVD_W'(CNT_FREQ_NUMER);
              dsr_r   <= DSR_W'(hz) * DSR_W'(CNT_FREQ_DENOM);
              rem_r   <= '0;
              cnt_r   <= '0;
              state_r <= R_DIV;
            end
          end
        end
        R_DIV: begin
          dvd_r <= dvd_step;
          rem_r <= rem_step;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            div_r   <= dvd_step[DIVR_W-1:0];
            state_r <= R_MUL;
          end
        end
        R_MUL: begin
          y_r     <= NPT_Y_W'(div_r) * NPT_Y_W'(NPT_REM);
          a_r     <= NPT_W'(div_r) * NPT_W'(NPT_INT);
          state_r <= R_EST;
        end
        R_EST: begin
          qe_r    <= pr[NPT_SHIFT +: NPT_Q_W];
          state_r <= R_CHK;
        end
        R_CHK: begin
          m_r     <= NPT_Y_W'(qe_r) * NPT_Y_W'(CNT_FREQ_NUMER);
          state_r <= R_FIX;
        end
        R_FIX: begin
          npt_r   <= a_r + NPT_W'(qe_r) + NPT_W'(fr >= NPT_Y_W'(CNT_FREQ_NUMER));
          state_r <= R_IDLE;
        end
        default: state_r <= R_IDLE;
      endcase
    end
  end

  assign rate.busy           = (state_r != R_IDLE);
  assign rate.reload_divisor = div_r;
  assign rate.ns_per_tick    = npt_r;

endmodule

// ===== hw/rtl/icn_sleep.sv =====
module icn_sleep (
  input  logic              clk,
  input  logic [2:0]        en,
  input  icn_pkg::in_item_t in_data,
  output icn_pkg::front_t   front
);
  import icn_pkg::*;

  in_item_t              item_r;

  cmd_t                  cmd1_r;
  logic [15:0]           rb1_r;
  logic                  big1_r;
  logic [58:0]           pk1_r;
  logic [31:0]           m1lo1_r;

  cmd_t                  cmd2_r;
  logic [15:0]           rb2_r;
  logic                  big2_r;
  logic [SLP_Q_W-1:0]    qe2_r;
  logic [31:0]           m1lo2_r;
  logic [31:0]           m2lo2_r;

  logic [SLP_Q_W-1:0]    qe1;
  logic [31:0]           r;
  logic [17:0]           c;
  logic [17:0]           cs;

  assign qe1 = pk1_r[SLP_SHIFT +: SLP_Q_W];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      item_r <= in_data;
    end
    if (en[1]) begin
      cmd1_r  <= item_r.command;
      rb1_r   <= item_r.counter_readback;
      // requests of 2^26 ns or more always saturate
      big1_r  <= |item_r.sleep_ns[63:SLP_NS_W];
      // estimate never exceeds the true count and falls short by at most one
      pk1_r   <= 59'(item_r.sleep_ns[SLP_NS_W-1:8]) * 59'(SLP_K);
      m1lo1_r <= item_r.sleep_ns[31:0] * 32'(FRAC_DEN);
    end
    if (en[2]) begin
      cmd2_r  <= cmd1_r;
      rb2_r   <= rb1_r;
      big2_r  <= big1_r;
      qe2_r   <= qe1;
      m1lo2_r <= m1lo1_r;
      m2lo2_r <= 32'(qe1) * 32'(FRAC_NUM);
    end
  end

  always_comb begin
    // remainder stays below twice the divisor, so the low word is enough
    r  = m1lo2_r - m2lo2_r;
    c  = 18'(qe2_r) + 18'(r >= 32'(FRAC_NUM));
    cs = c + SLEEP_SKID;
    front.command = cmd2_r;
    front.rb      = rb2_r;
    front.cnt     = (big2_r || cs > SLEEP_MAX) ? SLEEP_MAX[15:0] : cs[15:0];
  end

endmodule

// ===== hw/rtl/icn_state.sv =====
module icn_state (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  logic            upd,
  input  icn_pkg::front_t front,
  input  icn_pkg::rate_t  rate,
  output icn_pkg::mid_t   mid
);
  import icn_pkg::*;

  logic [63:0] clock_r, clock_nxt;
  logic [63:0] ticks_r, ticks_nxt;
  logic [15:0] armed_r, armed_nxt;
  mid_t        mid_r, mid_nxt;

  always_comb begin
    clock_nxt = clock_r;
    ticks_nxt = ticks_r;
    armed_nxt = armed_r;
    mid_nxt.base   = '0;
    mid_nxt.x      = '0;
    case (front.command)
      CMD_TICK: begin
        clock_nxt    = clock_r + 64'(rate.ns_per_tick);
        ticks_nxt    = ticks_r + 64'd1;
        mid_nxt.base = clock_nxt;
      end
      CMD_QUERY: begin
        mid_nxt.base = clock_r;
        // readback above the divisor clamps to zero
        if (rate.reload_divisor > front.rb) begin
          mid_nxt.x = rate.reload_divisor - front.rb;
        end
      end
      CMD_SLEEP_START: begin
        armed_nxt    = front.cnt;
        mid_nxt.base = 64'(front.cnt);
      end
      CMD_SLEEP_END: begin
        if (armed_r > front.rb) begin
          mid_nxt.x = armed_r - front.rb;
        end
      end
      default: begin
      end
    endcase
    mid_nxt.ticks  = ticks_nxt;
    mid_nxt.reload = rate.reload_divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
      ticks_r <= '0;
      armed_r <= '0;
    end else if (upd) begin
      clock_r <= clock_nxt;
      ticks_r <= ticks_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mid_r <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

// ===== hw/rtl/icn_scale.sv =====
module icn_scale (
  input  logic               clk,
  input  logic [3:0]         en,
  input  icn_pkg::mid_t      mid,
  output icn_pkg::out_item_t out_data
);
  import icn_pkg::*;

  logic [32:0]        y4_r;
  logic [25:0]        a4_r;
  logic [63:0]        base4_r;
  logic [63:0]        ticks4_r;
  logic [15:0]        reload4_r;

  logic [SCL_Q_W-1:0] qe5_r;
  logic [21:0]        ylo5_r;
  logic [63:0]        basea5_r;
  logic [63:0]        ticks5_r;
  logic [15:0]        reload5_r;

  logic [SCL_Q_W-1:0] qe6_r;
  logic [21:0]        ylo6_r;
  logic [21:0]        mlo6_r;
  logic [63:0]        basea6_r;
  logic [63:0]        ticks6_r;
  logic [15:0]        reload6_r;

  out_item_t          out_r;

  logic [58:0]        pr;
  logic [21:0]        r;

  assign pr = 59'(y4_r) * 59'(SCL_RECIP);
  assign r  = ylo6_r - mlo6_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      y4_r      <= 33'(mid.x) * 33'(SCL_REM);
      a4_r      <= 26'(mid.x) * 26'(SCL_INT);
      base4_r   <= mid.base;
      ticks4_r  <= mid.ticks;
      reload4_r <= mid.reload;
    end
    if (en[1]) begin
      // quotient estimate, low by at most one
      qe5_r     <= pr[SCL_SHIFT +: SCL_Q_W];
      ylo5_r    <= y4_r[21:0];
      basea5_r  <= base4_r + 64'(a4_r);
      ticks5_r  <= ticks4_r;
      reload5_r <= reload4_r;
    end
    if (en[2]) begin
      qe6_r     <= qe5_r;
      ylo6_r    <= ylo5_r;
      mlo6_r    <= 22'(qe5_r) * 22'(FRAC_DEN);
      basea6_r  <= basea5_r;
      ticks6_r  <= ticks5_r;
      reload6_r <= reload5_r;
    end
    if (en[3]) begin
      out_r.value        <= basea6_r + 64'(qe6_r) + 64'(r >= 22'(FRAC_DEN));
      out_r.tick_count   <= ticks6_r;
      out_r.reload_value <= reload6_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/interpolating_nanosecond_clock_core.sv =====
// nanosecond clock for a periodic counter at 3579545/3 Hz
// input channel (in_valid, in_stall, in_data): one command per transfer,
//   tick, time query, sleep start or sleep end
// result channel (out_valid, out_stall, out_data): exactly one result per
//   command, in command order
// cfg_we/cfg_wdata: writes the requested tick rate; the reload divisor comes
//   from a serial divider, one quotient bit per cycle; ns per tick then
//   follows by constant multiply and correction (R_MUL, R_EST, R_CHK, R_FIX,
//   no divider when the rate is 18 or below); in_stall stays high meanwhile
// pipeline: a result becomes valid after passing through an 8-register
//   pipeline (input, two sleep-conversion stages, state stage, three
//   scaling stages, output register)
// throughput: one command per cycle unless stalled; state is read and written
//   only in the state stage, so back-to-back commands see each other's updates
// a stalled result holds in the output register; earlier stages keep filling
//   bubbles and in_stall rises only when the whole pipeline is full or rate.busy
// reset: clock and tick count zero, no armed sleep, rate 20 Hz
//   (divisor 59659, 49999930 ns per tick), pipeline empty
module interpolating_nanosecond_clock_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  icn_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output icn_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic [icn_pkg::RATE_W-1:0] cfg_wdata
);
  import icn_pkg::*;

  logic [STAGES-1:0] v_r, v_nxt, en;
  logic              in_xfer;
  rate_t             rate;
  front_t            front;
  mid_t              mid;

  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall = !en[0] || rate.busy;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    v_nxt[0] = en[0] ? in_xfer : v_r[0];
    for (int i = 1; i < STAGES; i++) begin
      v_nxt[i] = en[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign out_valid = v_r[STAGES-1];

  icn_rate u_rate (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .rate      (rate)
  );

  icn_sleep u_sleep (
    .clk     (clk),
    .en      (en[2:0]),
    .in_data (in_data),
    .front   (front)
  );

  icn_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (en[3]),
    .upd   (en[3] && v_r[2]),
    .front (front),
    .rate  (rate),
    .mid   (mid)
  );

  icn_scale u_scale (
    .clk      (clk),
    .en       (en[7:4]),
    .mid      (mid),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    rate.busy |-> in_stall)
    else $error("input transfer possible while rate unit busy");

  a_xfer_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> v_r[0])
    else $error("accepted command lost at input register");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[6] && en[7]) |=> out_valid)
    else $error("result did not reach output register");

  a_output_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !v_r[6]) |=> !out_valid)
    else $error("result repeated after transfer");
`endif

endmodule
